// ===== src/hcbd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the chunked body decoder.
// No dependencies; imported by the front, queue, back and top modules.
package hcbd_pkg;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  // Digit limit register
  localparam int unsigned     DIGIT_W          = 7;
  localparam logic [DIGIT_W-1:0] MAX_DIGITS_RESET = 7'd100;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
  } cls_t;

  // Decoder phase
  typedef enum logic [9:0] {
    PH_SIZE     = 10'b00_0000_0001,
    PH_EXT      = 10'b00_0000_0010,
    PH_SIZE_LF  = 10'b00_0000_0100,
    PH_DATA     = 10'b00_0000_1000,
    PH_DATA_CR  = 10'b00_0001_0000,
    PH_DATA_LF  = 10'b00_0010_0000,
    PH_TRAILER  = 10'b00_0100_0000,
    PH_TRAIL_LF = 10'b00_1000_0000,
    PH_DONE     = 10'b01_0000_0000,
    PH_ERROR    = 10'b10_0000_0000
  } phase_t;

endpackage

// ===== src/http_chunked_body_decoder_core.sv =====
`timescale 1ns / 1ps
// HTTP chunked body decoder, top level. Depends on hcbd_pkg, hcbd_front,
// hcbd_queue and hcbd_back.
// An accepted input byte is stored in the queue, then in the output register.
// Throughput: one byte per clock unless stalled; framing updates once per byte.
// Reset (rst, synchronous): empties the queue and output register, restarts at
// the chunk size line, and sets max_digits to 100.
module http_chunked_body_decoder_core import hcbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [DIGIT_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         byte_out,
  output logic               is_payload,
  output logic               last_of_chunk,
  output logic               body_done,
  output logic               parse_error
);

  logic push;
  cls_t push_item;
  logic q_full;
  logic q_not_empty;
  cls_t q_head;
  logic pop;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  hcbd_front u_front (
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .q_full    (q_full),
    .in_stall  (in_stall),
    .push      (push),
    .push_item (push_item)
  );

  hcbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  hcbd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .byte_out      (byte_out),
    .is_payload    (is_payload),
    .last_of_chunk (last_of_chunk),
    .body_done     (body_done),
    .parse_error   (parse_error)
  );

  // Non-payload results carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_payload |-> byte_out == 8'h00)
    else $error("byte_out nonzero on a non-payload result");

  // End of chunk only marks a payload byte
  a_last_is_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_chunk |-> is_payload)
    else $error("last_of_chunk without payload");

  // Done and error are exclusive, and neither carries payload
  a_terminal_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(body_done && parse_error) &&
                  !((body_done || parse_error) && is_payload))
    else $error("inconsistent terminal flags");

  // A queued byte is drained whenever the output register is free
  a_drain: assert property (@(posedge clk) disable iff (rst)
    q_not_empty && !out_valid |-> pop)
    else $error("queue not drained into a free output register");

endmodule

// ===== src/hcbd_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts raw body bytes and classifies them (hex digit, CR, LF).
// Depends on hcbd_pkg; pushes classified bytes into hcbd_queue.
module hcbd_front import hcbd_pkg::*; (
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       in_stall,
  output logic       push,
  output cls_t       push_item
);

  logic is_dec;
  logic is_upper;
  logic is_lower;

  // Hold the sender off while the queue is full
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Classify the byte
  assign is_dec   = (in_byte >= CH_0)  && (in_byte <= CH_9);
  assign is_upper = (in_byte >= CH_UA) && (in_byte <= CH_UF);
  assign is_lower = (in_byte >= CH_LA) && (in_byte <= CH_LF_HEX);

  always_comb begin
    push_item.data    = in_byte;
    push_item.is_hex  = is_dec || is_upper || is_lower;
    // Letters a-f / A-F have low nibble 1..6, value is nibble plus 9
    push_item.hex_val = is_dec ? in_byte[3:0] : in_byte[3:0] + 4'd9;
    push_item.is_cr   = (in_byte == CH_CR);
    push_item.is_lf   = (in_byte == CH_LF);
  end

endmodule

// ===== src/hcbd_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of classified bytes between front and back ends.
// Depends on hcbd_pkg for the item type and depth.
module hcbd_queue import hcbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t push_item,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cls_t head
);

  cls_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/hcbd_back.sv =====
`timescale 1ns / 1ps
// Back end: chunk framing state machine, digit limit register and output register.
// Depends on hcbd_pkg; takes classified bytes from hcbd_queue.
module hcbd_back import hcbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr,
  input  logic [DIGIT_W-1:0] cfg_data,
  input  logic               q_not_empty,
  input  cls_t               q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         byte_out,
  output logic               is_payload,
  output logic               last_of_chunk,
  output logic               body_done,
  output logic               parse_error
);

  phase_t                phase, phase_next;
  logic [SIZE_BITS-1:0]  size_accum, size_accum_next;
  logic [SIZE_BITS-1:0]  bytes_left, bytes_left_next;
  logic [DIGIT_W-1:0]    digit_count, digit_count_next;
  logic                  at_line_start, at_line_start_next;
  logic [DIGIT_W-1:0]    max_digits;
  logic                  payload_next;
  logic                  last_next;

  // Take a byte when the output register is free or being drained
  assign pop = q_not_empty && (!out_valid || !out_stall);

  // Digit limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_digits <= MAX_DIGITS_RESET;
    end else if (cfg_wr) begin
      max_digits <= cfg_data;
    end
  end

  // Framing state machine
  always_comb begin
    phase_next         = phase;
    size_accum_next    = size_accum;
    bytes_left_next    = bytes_left;
    digit_count_next   = digit_count;
    at_line_start_next = at_line_start;
    payload_next       = 1'b0;
    last_next          = 1'b0;
    unique case (phase)
      PH_SIZE: begin
        if (q_head.is_hex) begin
          if (digit_count >= max_digits ||
              size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_next = PH_ERROR;
          end else begin
            digit_count_next = digit_count + 1'b1;
            size_accum_next  = {size_accum[SIZE_BITS-5:0], q_head.hex_val};
          end
        end else if (digit_count == '0) begin
          phase_next = PH_ERROR;
        end else if (q_head.is_cr) begin
          phase_next = PH_SIZE_LF;
        end else begin
          phase_next = PH_EXT;
        end
      end
      PH_EXT: begin
        if (q_head.is_cr) begin
          phase_next = PH_SIZE_LF;
        end
      end
      PH_SIZE_LF: begin
        if (!q_head.is_lf) begin
          phase_next = PH_ERROR;
        end else if (size_accum == '0) begin
          at_line_start_next = 1'b1;
          phase_next         = PH_TRAILER;
        end else begin
          bytes_left_next = size_accum;
          phase_next      = PH_DATA;
        end
      end
      PH_DATA: begin
        payload_next    = 1'b1;
        bytes_left_next = bytes_left - 1'b1;
        if (bytes_left == SIZE_BITS'(1)) begin
          last_next  = 1'b1;
          phase_next = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        phase_next = q_head.is_cr ? PH_DATA_LF : PH_ERROR;
      end
      PH_DATA_LF: begin
        if (q_head.is_lf) begin
          size_accum_next  = '0;
          digit_count_next = '0;
          phase_next       = PH_SIZE;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_TRAILER: begin
        if (q_head.is_cr) begin
          phase_next = PH_TRAIL_LF;
        end else begin
          at_line_start_next = 1'b0;
        end
      end
      PH_TRAIL_LF: begin
        if (!q_head.is_lf) begin
          phase_next = PH_ERROR;
        end else if (at_line_start) begin
          phase_next = PH_DONE;
        end else begin
          at_line_start_next = 1'b1;
          phase_next         = PH_TRAILER;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase
  end

  // Update state on each byte taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      size_accum    <= '0;
      bytes_left    <= '0;
      digit_count   <= '0;
      at_line_start <= 1'b1;
    end else if (pop) begin
      phase         <= phase_next;
      size_accum    <= size_accum_next;
      bytes_left    <= bytes_left_next;
      digit_count   <= digit_count_next;
      at_line_start <= at_line_start_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (pop) begin
      byte_out      <= payload_next ? q_head.data : 8'h00;
      is_payload    <= payload_next;
      last_of_chunk <= last_next;
      body_done     <= (phase_next == PH_DONE);
      parse_error   <= (phase_next == PH_ERROR);
    end
  end

endmodule
